>>> hdl/cmts_pkg.sv
// Shared types, constants and gamma table for the cube map texel sampler.
package cmts_pkg;

	localparam int MAX_SIDE_DEF        = 64;
	localparam int MAX_TEXEL_BYTES_DEF = 4;
	localparam int FACE_COUNT          = 6;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_WRITE  = 1'b1;

	localparam logic [1:0] REG_SIDE_WIDTH      = 2'd0;
	localparam logic [1:0] REG_BYTES_PER_TEXEL = 2'd1;
	localparam logic [1:0] REG_BRIGHTNESS      = 2'd2;

	typedef struct packed {
		logic               action;
		logic        [2:0]  face;
		logic        [13:0] byte_address;
		logic        [7:0]  byte_value;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} in_item_t;

	typedef struct packed {
		logic [23:0] red;
		logic [23:0] green;
		logic [23:0] blue;
		logic        bad_direction;
	} out_item_t;

	typedef logic [15:0] gamma_rom_t [0:255];

	// r^5 in Q0.32 with r in Q0.20, each product truncated
	function automatic logic [63:0] fifth_power_q32(logic [63:0] r);
		logic [63:0] r32;
		logic [63:0] p;
		r32 = r << 12;
		p   = r32;
		for (int k = 0; k < 4; k++) begin
			p = (p * r32) >> 32;
		end
		return p;
	endfunction

	function automatic logic [15:0] gamma_value(int i);
		logic [63:0] q;
		logic [63:0] s;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] g;
		q  = (64'(i) << 32) / 64'd255;
		s  = ((64'(i) * 64'(i)) << 32) / 64'd65025;
		lo = 64'd0;
		hi = 64'd1048575;
		for (int n = 0; n < 21; n++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (fifth_power_q32(mid) <= q) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
		end
		g = (s * lo + (64'd1 << 35)) >> 36;
		return (g > 64'd65535) ? 16'hFFFF : g[15:0];
	endfunction

	function automatic gamma_rom_t gamma_table();
		gamma_rom_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = gamma_value(i);
		end
		return t;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = gamma_table();

endpackage

>>> hdl/cube_map_texel_sampler.sv
// Cube map texel sampler: face select, texel divide, byte store, gamma and gain.
//
// Usage: in_valid/in_stall carries one item per transfer. A write item stores
// one texture byte; a sample item carries a signed direction and yields one
// result on out_valid/out_stall (red, green, blue in Q8.16, bad_direction).
// Configuration (side_width, bytes_per_texel, brightness) is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// A sample passes three input stages, one divider stage per quotient bit,
// two address stages, three byte reads and the gamma/gain stage into a
// four-entry output queue. A sample holds the single byte-wide texture
// port for three reads (blue, green, red) and a write for one access;
// other stages overlap.
// Reset clears control state and the registers to 64, 3 and 256; the texture
// memory is not cleared and reads garbage until written.
// When out_stall is held the queue fills; the port admits no new sample
// while four results are owed, and in_stall then rises.
module cube_map_texel_sampler #(
	parameter int MAX_SIDE        = cmts_pkg::MAX_SIDE_DEF,
	parameter int MAX_TEXEL_BYTES = cmts_pkg::MAX_TEXEL_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cmts_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output cmts_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import cmts_pkg::*;

	localparam int SW         = $clog2(MAX_SIDE + 1);
	localparam int QW         = SW;
	localparam int NW         = 17 + SW;
	localparam int LW         = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int FACE_BYTES = MAX_SIDE * MAX_SIDE * MAX_TEXEL_BYTES;
	localparam int MEM_DEPTH  = FACE_COUNT * FACE_BYTES;
	localparam int AW         = $clog2(MEM_DEPTH);
	localparam int FIFO_DEPTH = 4;
	localparam int FPW        = 2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	typedef struct packed {
		logic        wr;
		logic [2:0]  face;
		logic [13:0] baddr;
		logic [7:0]  bval;
		logic        bad;
	} ctl_t;

	// configuration
	logic [6:0]    side_q;
	logic [2:0]    bpt_q;
	logic [15:0]   bright_q;
	logic [SW-1:0] side_eff;
	logic          bpt4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= 7'd64;
			bpt_q    <= 3'd3;
			bright_q <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_WIDTH:      side_q   <= cfg_data[6:0];
				REG_BYTES_PER_TEXEL: bpt_q    <= cfg_data[2:0];
				REG_BRIGHTNESS:      bright_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (side_q == 7'd0) begin
			side_eff = SW'(1);
		end else if (32'(side_q) > MAX_SIDE) begin
			side_eff = SW'(MAX_SIDE);
		end else begin
			side_eff = SW'(side_q);
		end
		bpt4 = (MAX_TEXEL_BYTES == 4) && (bpt_q >= 3'd4);
	end

	logic adv;
	assign in_stall = !adv;

	// S1: input register
	logic     s1_valid;
	in_item_t s1_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_item <= in_data;
		end
	end

	// S2: major axis, face and shifted minor components
	logic signed [16:0] ex, ey, ez;
	logic [16:0]        ax, ay, az, am;
	logic [1:0]         major;
	logic signed [15:0] dm, du, dv;
	logic signed [17:0] su, sv;
	ctl_t               ctl_in;

	always_comb begin
		ex = {s1_item.dir_x[15], s1_item.dir_x};
		ey = {s1_item.dir_y[15], s1_item.dir_y};
		ez = {s1_item.dir_z[15], s1_item.dir_z};
		ax = (ex < 0) ? 17'(-ex) : 17'(ex);
		ay = (ey < 0) ? 17'(-ey) : 17'(ey);
		az = (ez < 0) ? 17'(-ez) : 17'(ez);
		priority if (ax > ay && ax > az) begin
			major = AXIS_X;
		end else if (ay > az) begin
			major = AXIS_Y;
		end else begin
			major = AXIS_Z;
		end
		unique case (major)
			AXIS_X: begin
				am = ax; dm = s1_item.dir_x; du = s1_item.dir_z; dv = s1_item.dir_y;
			end
			AXIS_Y: begin
				am = ay; dm = s1_item.dir_y; du = s1_item.dir_x; dv = s1_item.dir_z;
			end
			default: begin
				am = az; dm = s1_item.dir_z; du = s1_item.dir_x; dv = s1_item.dir_y;
			end
		endcase
		su = {{2{du[15]}}, du} + $signed({1'b0, am});
		sv = {{2{dv[15]}}, dv} + $signed({1'b0, am});
		ctl_in.wr    = (s1_item.action == ACT_WRITE);
		ctl_in.face  = ctl_in.wr ? s1_item.face : {major, ~(dm > 0)};
		ctl_in.baddr = s1_item.byte_address;
		ctl_in.bval  = s1_item.byte_value;
		ctl_in.bad   = (ax == 17'd0) && (ay == 17'd0) && (az == 17'd0);
	end

	logic        s2_valid;
	ctl_t        s2_ctl;
	logic [16:0] s2_nu, s2_nv, s2_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_ctl <= ctl_in;
			s2_nu  <= su[16:0];
			s2_nv  <= sv[16:0];
			s2_den <= {am[15:0], 1'b0};
		end
	end

	// S3 and divider: restoring division, one quotient bit per stage
	logic          dv_valid [0:QW];
	ctl_t          dv_ctl   [0:QW];
	logic [NW-1:0] dv_ru    [0:QW];
	logic [NW-1:0] dv_rv    [0:QW];
	logic [16:0]   dv_den   [0:QW];
	logic [QW-1:0] dv_qu    [0:QW];
	logic [QW-1:0] dv_qv    [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_valid[0] <= 1'b0;
		end else if (adv) begin
			dv_valid[0] <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ctl[0] <= s2_ctl;
			dv_ru[0]  <= NW'(s2_nu) * NW'(side_eff);
			dv_rv[0]  <= NW'(s2_nv) * NW'(side_eff);
			dv_den[0] <= s2_den;
			dv_qu[0]  <= '0;
			dv_qv[0]  <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [NW-1:0] dsh;
		logic          ge_u, ge_v;

		assign dsh  = NW'(dv_den[j]) << K;
		assign ge_u = (dv_ru[j] >= dsh);
		assign ge_v = (dv_rv[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid[j+1] <= 1'b0;
			end else if (adv) begin
				dv_valid[j+1] <= dv_valid[j];
			end
		end

		// bit K is still clear here; later stages fill the lower bits
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctl[j+1] <= dv_ctl[j];
				dv_den[j+1] <= dv_den[j];
				dv_ru[j+1]  <= ge_u ? dv_ru[j] - dsh : dv_ru[j];
				dv_rv[j+1]  <= ge_v ? dv_rv[j] - dsh : dv_rv[j];
				dv_qu[j+1]  <= dv_qu[j] | (QW'(ge_u) << K);
				dv_qv[j+1]  <= dv_qv[j] | (QW'(ge_v) << K);
			end
		end
	end

	// T: clamp and linear texel index
	logic [SW-1:0] side_m1, tx, ty;
	logic          t_valid;
	ctl_t          t_ctl;
	logic [LW-1:0] t_lin;

	always_comb begin
		side_m1 = side_eff - SW'(1);
		tx = (dv_qu[QW] > side_m1) ? side_m1 : dv_qu[QW];
		ty = (dv_qv[QW] > side_m1) ? side_m1 : dv_qv[QW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_valid <= 1'b0;
		end else if (adv) begin
			t_valid <= dv_valid[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_ctl <= dv_ctl[QW];
			t_lin <= LW'(LW'(ty) * LW'(side_eff) + LW'(tx));
		end
	end

	// B: byte address
	logic          b_valid;
	ctl_t          b_ctl;
	logic [AW-1:0] b_addr;
	logic          b_wok;
	logic [AW-1:0] face_base, lin_a, texel_off;

	always_comb begin
		face_base = AW'(t_ctl.face) * AW'(FACE_BYTES);
		lin_a     = AW'(t_lin);
		texel_off = bpt4 ? (lin_a << 2) : (lin_a + (lin_a << 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid <= 1'b0;
		end else if (adv) begin
			b_valid <= t_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_ctl  <= t_ctl;
			b_addr <= face_base + (t_ctl.wr ? AW'(t_ctl.baddr) : texel_off);
			b_wok  <= (32'(t_ctl.face) < FACE_COUNT) && (32'(t_ctl.baddr) < FACE_BYTES);
		end
	end

	// M: texture port; a sample issues three reads, a write one write
	logic          m_valid_q;
	ctl_t          m_ctl_q;
	logic [AW-1:0] m_addr_q;
	logic          m_wok_q;
	logic [1:0]    m_seq_q;
	logic [2:0]    credit_q;
	logic          credit_ok, m_issue, m_done, m_start;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem [0:MEM_DEPTH-1];
	logic [7:0]    mem_rdata_q;

	assign credit_ok = (credit_q < 3'(FIFO_DEPTH));
	assign m_issue   = m_valid_q && !m_ctl_q.wr && (m_seq_q != CH_BLUE || credit_ok);
	assign m_start   = m_issue && (m_seq_q == CH_BLUE);
	assign m_done    = m_valid_q && (m_ctl_q.wr || (m_issue && m_seq_q == CH_RED));
	assign adv       = !m_valid_q || m_done;
	assign mem_we    = m_valid_q && m_ctl_q.wr && m_wok_q;
	assign mem_addr  = m_addr_q + AW'(m_seq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_seq_q   <= CH_BLUE;
		end else if (adv) begin
			m_valid_q <= b_valid;
			m_seq_q   <= CH_BLUE;
		end else if (m_issue) begin
			m_seq_q   <= m_seq_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_ctl_q  <= b_ctl;
			m_addr_q <= b_addr;
			m_wok_q  <= b_wok;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= m_ctl_q.bval;
		end
		mem_rdata_q <= mem[mem_addr];
	end

	// read return and color assembly
	logic       rd_valid_q;
	logic [1:0] rd_ch_q;
	logic       rd_bad_q;
	logic [7:0] blue_q, green_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= m_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_ch_q  <= m_seq_q;
		rd_bad_q <= m_ctl_q.bad;
		if (rd_valid_q && rd_ch_q == CH_BLUE) begin
			blue_q <= mem_rdata_q;
		end
		if (rd_valid_q && rd_ch_q == CH_GREEN) begin
			green_q <= mem_rdata_q;
		end
	end

	logic      push, pop;
	out_item_t res;
	logic [31:0] prod_r, prod_g, prod_b;

	assign push = rd_valid_q && (rd_ch_q == CH_RED);

	always_comb begin
		prod_r = 32'(GAMMA_ROM[mem_rdata_q]) * 32'(bright_q);
		prod_g = 32'(GAMMA_ROM[green_q]) * 32'(bright_q);
		prod_b = 32'(GAMMA_ROM[blue_q]) * 32'(bright_q);
		if (rd_bad_q) begin
			res = '{red: 24'd0, green: 24'd0, blue: 24'd0, bad_direction: 1'b1};
		end else begin
			res = '{red: prod_r[31:8], green: prod_g[31:8], blue: prod_b[31:8],
				bad_direction: 1'b0};
		end
	end

	// result queue; credits bound samples in flight to its depth
	out_item_t       fifo_q [0:FIFO_DEPTH-1];
	logic [FPW-1:0]  wptr_q, rptr_q;
	logic [FPW:0]    count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = fifo_q[rptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			count_q  <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + FPW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FPW'(1);
			end
			count_q  <= count_q + (FPW+1)'(push) - (FPW+1)'(pop);
			credit_q <= credit_q + 3'(m_start) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= res;
		end
	end

endmodule

>>> hdl/cmts_check.sv
// Port-level checks for the cube map texel sampler, with its bind.
module cmts_check (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input cmts_pkg::out_item_t out_data
);
	import cmts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_direction |->
			out_data.red == 24'd0 && out_data.green == 24'd0 && out_data.blue == 24'd0)
		else $error("bad direction with nonzero color");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind cube_map_texel_sampler cmts_check u_cmts_check (.*);
